[sv/rss_pkg.sv]
package rss_pkg;

    localparam int unsigned DATA_WORDS_DEF = 1024;

    // Data processing opcodes, bits 24:21.
    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_MVN = 4'd15;

    // Branch condition codes, bits 31:28.
    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    // Instruction classes, bits 27:24.
    localparam logic [3:0] CLS_BRANCH = 4'd10;
    localparam logic [3:0] CLS_SWI    = 4'd15;

    // Load/store forms, bits 25:20.
    localparam logic [5:0] FORM_STR = 6'd24;
    localparam logic [5:0] FORM_LDR = 6'd25;

    // Software interrupt codes, bits 23:0.
    localparam logic [23:0] SWI_SPACE = 24'd0;
    localparam logic [23:0] SWI_EXIT  = 24'd17;
    localparam logic [23:0] SWI_PRINT = 24'd107;
    localparam logic [23:0] SWI_READ  = 24'd108;

    // Shift types, bits 6:5.
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [3:0] REG_READ  = 4'd0;
    localparam logic [3:0] REG_PRINT = 4'd1;
    localparam logic [3:0] REG_PC    = 4'd15;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_PRINT_INT   = 3'd1,
        EV_PRINT_SPACE = 3'd2,
        EV_READ_INT    = 3'd3,
        EV_EXIT        = 3'd4
    } event_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic [2:0]  event_code;
        logic [31:0] print_value;
        logic        halted;
    } rss_res_t;

endpackage

[sv/rss_if.sv]
interface rss_instr_if;
    logic               valid;
    logic               ready;
    logic [31:0]        instruction_word;
    logic signed [31:0] read_value;

    modport source (output valid, output instruction_word, output read_value, input ready);
    modport sink (input valid, input instruction_word, input read_value, output ready);
endinterface

interface rss_result_if;
    logic               valid;
    logic               ready;
    logic [31:0]        next_pc;
    logic               reg_write;
    logic [3:0]         reg_index;
    logic [31:0]        reg_value;
    logic [2:0]         event_code;
    logic signed [31:0] print_value;
    logic               halted;

    modport source (output valid, output next_pc, output reg_write, output reg_index,
                    output reg_value, output event_code, output print_value,
                    output halted, input ready);
    modport sink (input valid, input next_pc, input reg_write, input reg_index,
                  input reg_value, input event_code, input print_value,
                  input halted, output ready);
endinterface

[sv/risc_subset_instruction_step.sv]
// The result is registered from the execute stage; a register-shifted operand first takes
// a step to read its shift register, and LDR then reads data memory into the load stage.
// LDR and STR add word-index reduction steps when DATA_WORDS is not a power of two.
// Throughput: 1 instruction per cycle while the result is not stalled; LDR's memory
// read, register-shifted operands (two register read ports) and the reduction hold it off.
// Reset clears control state, then a pass over every data word zeroes both memories.
module risc_subset_instruction_step
    import rss_pkg::*;
#(
    parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    rss_instr_if.sink     instr,
    rss_result_if.source  result
);

    localparam int unsigned AW         = $clog2(DATA_WORDS);
    localparam bit          DW_POW2    = ((2 ** AW) == DATA_WORDS);
    localparam int unsigned SH         = 30 + AW;
    localparam logic [63:0] RECIP_FULL = (64'd1 << SH) / 64'(DATA_WORDS);
    localparam logic [30:0] RECIP      = RECIP_FULL[30:0];
    localparam logic [1:0]  LS_LAST    = DW_POW2 ? 2'd0 : 2'd3;
    localparam logic [AW-1:0] CLR_LAST = AW'(DATA_WORDS - 1);
    localparam logic [29:0] DW_30      = 30'(DATA_WORDS);

    function automatic logic [3:0] addr_a(input logic [31:0] iw);
        return (iw[27:24] == CLS_SWI) ? REG_PRINT : iw[19:16];
    endfunction

    function automatic logic [3:0] addr_b(input logic [31:0] iw);
        return (iw[27:26] == 2'b01) ? iw[15:12] : iw[3:0];
    endfunction

    function automatic logic [31:0] fwd_val(input logic [3:0] idx, input logic [31:0] q,
                                            input logic [31:0] pcv, input logic bv,
                                            input logic [3:0] bi, input logic [31:0] bd);
        logic [31:0] v;
        if (idx == REG_PC)
            v = pcv;
        else if (bv && (bi == idx))
            v = bd;
        else
            v = q;
        return v;
    endfunction

    // Returns {carry, value}.
    function automatic logic [32:0] shift_by(input logic [1:0] typ, input logic [31:0] v,
                                             input logic [7:0] amt, input logic cin);
        logic [32:0] ext;
        logic [63:0] rot;
        logic        big;
        logic [32:0] res;
        big = (amt[7:5] != 3'd0);
        ext = '0;
        rot = '0;
        res = {cin, v};
        if (amt != 8'd0)
        begin
            unique case (typ)
                SH_LSL:
                begin
                    ext = {1'b0, v} << amt[4:0];
                    if (!big)
                        res = ext;
                    else
                        res = {(amt == 8'd32) ? v[0] : 1'b0, 32'd0};
                end
                SH_LSR:
                begin
                    ext = {v, 1'b0} >> amt[4:0];
                    if (!big)
                        res = {ext[0], ext[32:1]};
                    else
                        res = {(amt == 8'd32) ? v[31] : 1'b0, 32'd0};
                end
                SH_ASR:
                begin
                    ext = 33'($signed({v, 1'b0}) >>> amt[4:0]);
                    if (!big)
                        res = {ext[0], ext[32:1]};
                    else
                        res = {v[31], {32{v[31]}}};
                end
                default:
                begin
                    rot = {v, v} >> amt[4:0];
                    res = {rot[31], rot[31:0]};
                end
            endcase
        end
        return res;
    endfunction

    // Memories.
    logic [31:0] rf_mem [16];
    logic [31:0] dmem [DATA_WORDS];

    // Control state.
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          s1_valid_reg, s1_valid_next;
    logic [1:0]    step_reg, step_next;
    logic          s2_valid_reg, s2_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   pc_reg;
    logic          n_reg, z_reg, c_reg, v_reg;
    logic          n_next, z_next, c_next, v_next;
    logic          halt_reg, halt_next;
    logic          byp_valid_reg;

    // Payload registers.
    logic [31:0]   s1_instr_reg;
    logic [31:0]   s1_rv_reg;
    logic [31:0]   rf_rd_a_reg, rf_rd_b_reg;
    logic [31:0]   opa_hold_reg, opb_hold_reg;
    logic [3:0]    byp_idx_reg;
    logic [31:0]   byp_val_reg;
    logic [29:0]   ls_word_reg;
    logic [60:0]   ls_prod_reg;
    logic [29:0]   ls_qd_reg;
    logic [3:0]    s2_rd_reg;
    logic [31:0]   dm_rd_reg;
    rss_res_t      out_res_reg;

    // Stage 1 decode and datapath.
    logic [31:0]   w;
    logic [3:0]    cls;
    logic          is_dp, is_ls, is_br, is_swi, dp_regsh;
    logic [31:0]   pc_plus4, pc_plus8, br_target;
    logic [31:0]   opa_now, opb_now, opa_use, opb_use, rs_val;
    logic [1:0]    sh_type;
    logic [4:0]    sh_imm;
    logic [7:0]    sh_amt;
    logic [31:0]   op_b;
    logic          sh_c;
    logic [3:0]    alu_op;
    logic          is_sub;
    logic [31:0]   add_b;
    logic          add_cin;
    logic [32:0]   add_sum;
    logic          add_v;
    logic [31:0]   dp_res;
    logic          dp_ok, dp_arith, dp_store, dp_s;
    logic          take;
    logic          ld_op, st_op;
    logic [31:0]   ls_addr;
    logic [29:0]   ls_rem, ls_rem_fix;
    logic [31:0]   ls_qd_full;
    logic [AW-1:0] mem_idx;
    rss_res_t      s1_res, s2_res;

    // Handshake and sequencing.
    logic          instr_accept, can_ret;
    logic [1:0]    s1_last;
    logic          s1_final, s1_adv, s1_ret, s1_to_s2, s2_ret, rs_fetch;

    // Memory ports.
    logic          rf_we;
    logic [3:0]    rf_wa, rf_ra_a, rf_ra_b;
    logic [31:0]   rf_wd;
    logic          rf_re_b;
    logic          dm_we;
    logic [AW-1:0] dm_wa;
    logic [31:0]   dm_wd;

    assign w        = s1_instr_reg;
    assign cls      = w[27:24];
    assign is_dp    = (cls[3:2] == 2'b00);
    assign is_ls    = (cls[3:2] == 2'b01);
    assign is_br    = (cls == CLS_BRANCH);
    assign is_swi   = (cls == CLS_SWI);
    assign dp_regsh = is_dp && !w[25] && w[4];

    assign pc_plus4  = pc_reg + 32'd4;
    assign pc_plus8  = pc_reg + 32'd8;
    assign br_target = pc_plus8 + {{6{w[23]}}, w[23:0], 2'b00};

    assign opa_now = fwd_val(addr_a(w), rf_rd_a_reg, pc_plus8, byp_valid_reg,
                             byp_idx_reg, byp_val_reg);
    assign opb_now = fwd_val(addr_b(w), rf_rd_b_reg, pc_plus8, byp_valid_reg,
                             byp_idx_reg, byp_val_reg);
    assign rs_val  = fwd_val(w[11:8], rf_rd_b_reg, pc_plus8, byp_valid_reg,
                             byp_idx_reg, byp_val_reg);
    assign opa_use = (step_reg == 2'd0) ? opa_now : opa_hold_reg;
    assign opb_use = (step_reg == 2'd0) ? opb_now : opb_hold_reg;

    assign sh_type = w[6:5];
    assign sh_imm  = w[11:7];

    always_comb
    begin
        sh_amt = {3'b000, sh_imm};
        op_b   = opb_use;
        sh_c   = c_reg;
        if (w[25])
        begin
            op_b = {24'd0, w[7:0]};
        end
        else if (w[4])
        begin
            {sh_c, op_b} = shift_by(sh_type, opb_use, rs_val[7:0], c_reg);
        end
        else if ((sh_imm == 5'd0) && (sh_type == SH_ROR))
        begin
            // Rotate right through carry.
            sh_c = opb_use[0];
            op_b = {c_reg, opb_use[31:1]};
        end
        else
        begin
            if ((sh_imm == 5'd0) && ((sh_type == SH_LSR) || (sh_type == SH_ASR)))
                sh_amt = 8'd32;
            {sh_c, op_b} = shift_by(sh_type, opb_use, sh_amt, c_reg);
        end
    end

    assign alu_op  = w[24:21];
    assign is_sub  = (alu_op == OP_SUB) || (alu_op == OP_CMP);
    assign add_b   = is_sub ? ~op_b : op_b;
    assign add_cin = is_sub ? 1'b1 : ((alu_op == OP_ADC) ? c_reg : 1'b0);
    assign add_sum = {1'b0, opa_use} + {1'b0, add_b} + {32'd0, add_cin};
    assign add_v   = ~(opa_use[31] ^ add_b[31]) & (opa_use[31] ^ add_sum[31]);

    // Word index of a load/store address, reduced modulo the memory depth.
    assign ls_addr    = opa_use + {20'd0, w[11:0]};
    assign ls_qd_full = 32'(ls_prod_reg[60:SH]) * 32'(DATA_WORDS);
    assign ls_rem     = ls_word_reg - ls_qd_reg;
    assign ls_rem_fix = (ls_rem >= DW_30) ? (ls_rem - DW_30) : ls_rem;
    assign mem_idx    = DW_POW2 ? ls_addr[AW+1:2] : ls_rem_fix[AW-1:0];

    always_comb
    begin
        s1_res         = '0;
        s1_res.next_pc = pc_plus4;
        n_next         = n_reg;
        z_next         = z_reg;
        c_next         = c_reg;
        v_next         = v_reg;
        halt_next      = halt_reg;
        dp_res         = '0;
        dp_ok          = 1'b1;
        dp_arith       = 1'b0;
        dp_store       = 1'b1;
        dp_s           = w[20];
        take           = 1'b0;
        ld_op          = 1'b0;
        st_op          = 1'b0;
        if (halt_reg)
        begin
            s1_res.next_pc = pc_reg;
            s1_res.halted  = 1'b1;
        end
        else if (is_dp)
        begin
            unique case (alu_op) inside
                OP_AND: dp_res = opa_use & op_b;
                OP_EOR: dp_res = opa_use ^ op_b;
                OP_SUB, OP_ADD, OP_ADC:
                begin
                    dp_res   = add_sum[31:0];
                    dp_arith = 1'b1;
                end
                OP_CMP:
                begin
                    dp_res   = add_sum[31:0];
                    dp_arith = 1'b1;
                    dp_store = 1'b0;
                    dp_s     = 1'b1;
                end
                OP_ORR: dp_res = opa_use | op_b;
                OP_MOV: dp_res = op_b;
                OP_MVN: dp_res = ~op_b;
                default: dp_ok = 1'b0;
            endcase
            if (dp_ok)
            begin
                if (dp_store)
                begin
                    s1_res.reg_write = 1'b1;
                    s1_res.reg_index = w[15:12];
                    s1_res.reg_value = dp_res;
                    if (w[15:12] == REG_PC)
                        s1_res.next_pc = {dp_res[31:2], 2'b00};
                end
                if (dp_s)
                begin
                    n_next = dp_res[31];
                    z_next = (dp_res == 32'd0);
                    c_next = dp_arith ? add_sum[32] : sh_c;
                    if (dp_arith)
                        v_next = add_v;
                end
            end
        end
        else if (is_ls)
        begin
            ld_op = (w[25:20] == FORM_LDR);
            st_op = (w[25:20] == FORM_STR);
        end
        else if (is_br)
        begin
            unique case (w[31:28])
                COND_EQ: take = z_reg;
                COND_NE: take = !z_reg;
                COND_GE: take = (n_reg == v_reg);
                COND_LT: take = (n_reg != v_reg);
                COND_GT: take = !z_reg && (n_reg == v_reg);
                COND_LE: take = z_reg || (n_reg != v_reg);
                COND_AL: take = 1'b1;
                default: take = 1'b0;
            endcase
            if (take)
                s1_res.next_pc = br_target;
        end
        else if (is_swi)
        begin
            unique case (w[23:0])
                SWI_EXIT:
                begin
                    halt_next         = 1'b1;
                    s1_res.event_code = EV_EXIT;
                    s1_res.next_pc    = pc_reg;
                    s1_res.halted     = 1'b1;
                end
                SWI_PRINT:
                begin
                    s1_res.event_code  = EV_PRINT_INT;
                    s1_res.print_value = opa_use;
                end
                SWI_SPACE: s1_res.event_code = EV_PRINT_SPACE;
                SWI_READ:
                begin
                    s1_res.event_code = EV_READ_INT;
                    s1_res.reg_write  = 1'b1;
                    s1_res.reg_index  = REG_READ;
                    s1_res.reg_value  = s1_rv_reg;
                end
                default: s1_res.event_code = EV_NONE;
            endcase
        end
    end

    always_comb
    begin
        s2_res           = '0;
        s2_res.reg_write = 1'b1;
        s2_res.reg_index = s2_rd_reg;
        s2_res.reg_value = dm_rd_reg;
        s2_res.next_pc   = (s2_rd_reg == REG_PC) ? {dm_rd_reg[31:2], 2'b00} : pc_plus4;
    end

    // Sequencing.
    assign can_ret  = !out_valid_reg || result.ready;
    assign s1_last  = halt_reg ? 2'd0 : (dp_regsh ? 2'd1 : (is_ls ? LS_LAST : 2'd0));
    assign s1_final = s1_valid_reg && (step_reg == s1_last);
    assign s1_adv   = s1_valid_reg && !s1_final;
    assign s1_ret   = s1_final && !ld_op && can_ret;
    assign s1_to_s2 = s1_final && ld_op;
    assign s2_ret   = s2_valid_reg && can_ret;
    assign rs_fetch = s1_adv && (step_reg == 2'd0) && dp_regsh;

    assign instr.ready  = !clearing_reg && (!s1_valid_reg || s1_ret)
                          && (!s2_valid_reg || s2_ret);
    assign instr_accept = instr.valid && instr.ready;

    always_comb
    begin
        step_next = step_reg;
        if (instr_accept)
            step_next = 2'd0;
        else if (s1_adv)
            step_next = step_reg + 2'd1;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (instr_accept)
            s1_valid_next = 1'b1;
        else if (s1_ret || s1_to_s2)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s1_to_s2)
            s2_valid_next = 1'b1;
        else if (s2_ret)
            s2_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_ret || s2_ret)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    // Memory port selection.
    assign rf_ra_a = addr_a(instr.instruction_word);
    assign rf_ra_b = instr_accept ? addr_b(instr.instruction_word) : w[11:8];
    assign rf_re_b = instr_accept || rs_fetch;

    always_comb
    begin
        rf_we = 1'b0;
        rf_wa = clr_cnt_reg[3:0];
        rf_wd = '0;
        if (clearing_reg)
        begin
            rf_we = 1'b1;
        end
        else if (s2_ret)
        begin
            rf_we = 1'b1;
            rf_wa = s2_res.reg_index;
            rf_wd = s2_res.reg_value;
        end
        else if (s1_ret && s1_res.reg_write)
        begin
            rf_we = 1'b1;
            rf_wa = s1_res.reg_index;
            rf_wd = s1_res.reg_value;
        end
    end

    assign dm_we = clearing_reg || (s1_ret && st_op);
    assign dm_wa = clearing_reg ? clr_cnt_reg : mem_idx;
    assign dm_wd = clearing_reg ? 32'd0 : opb_use;

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rf_wa] <= rf_wd;
        if (instr_accept)
            rf_rd_a_reg <= rf_mem[rf_ra_a];
        if (rf_re_b)
            rf_rd_b_reg <= rf_mem[rf_ra_b];
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
            dmem[dm_wa] <= dm_wd;
        if (s1_to_s2)
            dm_rd_reg <= dmem[mem_idx];
    end

    always_ff @(posedge clk)
    begin
        if (instr_accept)
        begin
            s1_instr_reg <= instr.instruction_word;
            s1_rv_reg    <= instr.read_value;
        end
        if (s1_adv && (step_reg == 2'd0))
        begin
            opa_hold_reg <= opa_now;
            opb_hold_reg <= opb_now;
            ls_word_reg  <= ls_addr[31:2];
        end
        if (s1_adv && (step_reg == 2'd1))
            ls_prod_reg <= 61'(ls_word_reg) * 61'(RECIP);
        if (s1_adv && (step_reg == 2'd2))
            ls_qd_reg <= ls_qd_full[29:0];
        if (s1_to_s2)
            s2_rd_reg <= w[15:12];
        if (s1_ret)
            out_res_reg <= s1_res;
        else if (s2_ret)
            out_res_reg <= s2_res;
        if (rf_we && !clearing_reg)
        begin
            byp_idx_reg <= rf_wa;
            byp_val_reg <= rf_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            step_reg      <= 2'd0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            n_reg         <= 1'b0;
            z_reg         <= 1'b0;
            c_reg         <= 1'b0;
            v_reg         <= 1'b0;
            halt_reg      <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                    clearing_reg <= 1'b0;
            end
            s1_valid_reg  <= s1_valid_next;
            step_reg      <= step_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_ret)
            begin
                pc_reg   <= s1_res.next_pc;
                n_reg    <= n_next;
                z_reg    <= z_next;
                c_reg    <= c_next;
                v_reg    <= v_next;
                halt_reg <= halt_next;
            end
            else if (s2_ret)
            begin
                pc_reg <= s2_res.next_pc;
            end
            if (rf_we && !clearing_reg)
                byp_valid_reg <= 1'b1;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.next_pc     = out_res_reg.next_pc;
    assign result.reg_write   = out_res_reg.reg_write;
    assign result.reg_index   = out_res_reg.reg_index;
    assign result.reg_value   = out_res_reg.reg_value;
    assign result.event_code  = out_res_reg.event_code;
    assign result.print_value = $signed(out_res_reg.print_value);
    assign result.halted      = out_res_reg.halted;

`ifndef SYNTHESIS
    a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && s2_valid_reg))
        else $error("Execute and load stages hold instructions at the same time.");

    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !instr.ready)
        else $error("An instruction can transfer during the memory clearing pass.");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("The halt mark was cleared after an exit.");

    a_load_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_to_s2 |=> (s2_valid_reg && !s1_valid_reg))
        else $error("A load did not move into the load stage.");
`endif

endmodule
